/* hw/rtl/assert_macros.svh */
// Shared assertion macros. Every assertion is clocked on i_clk and is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// If the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

    // Number of entries in the queue between the front and back parts.
    localparam int FifoDepth = 2;

    // ASCII code of the padding character '='.
    localparam logic [7:0] PadChar = 8'd61;

    // One completed group: 24 bits of data, the number of trailing pad
    // characters (0 to 2), and a flag for the end of the message.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  npad;
        logic        last;
    } t_group;

    // Maps a 6-bit value to its character in the standard alphabet.
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v <= 6'd25) begin
            return w + 8'd65;
        end else if (v <= 6'd51) begin
            return w + 8'd71;
        end else if (v <= 6'd61) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'd43;
        end else begin
            return 8'd47;
        end
    endfunction

endpackage

/* hw/rtl/base64_encoder_unit.sv */
// A byte that closes a group is written into the group queue, then loaded
// into the one-character output register, and only then is its first
// character offered on o_valid; the four characters of a group follow in
// order, one per cycle while i_ready is high. The output register thus sets
// the pace at four characters per group; short bursts at one byte per cycle,
// taken while the group queue is not full, are absorbed by the queue.
// Reset: synchronous, active low; clears the open group and empties the queue.
module base64_encoder_unit #(
    parameter int FIFO_DEPTH = b64e_pkg::FifoDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    b64e_pkg::t_group push_group;
    b64e_pkg::t_group head_group;
    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push),
        .o_group     (push_group)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (full),
        .o_valid (head_valid),
        .o_group (head_group),
        .i_pop   (pop)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_group     (head_group),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

/* hw/rtl/b64e_front.sv */
`include "assert_macros.svh"

module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_full,
    output logic                o_push,
    output b64e_pkg::t_group    o_group
);

    logic [7:0] r_pend0, n_pend0;
    logic [7:0] r_pend1, n_pend1;
    logic [1:0] r_cnt,   n_cnt;
    logic       accept;

    // Input is held off whenever the queue is full, even for bytes that
    // would only be stored.
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_pend0      = r_pend0;
        n_pend1      = r_pend1;
        n_cnt        = r_cnt;
        o_push       = 1'b0;
        o_group.bits = {r_pend0, r_pend1, i_data_byte};
        o_group.npad = 2'd0;
        o_group.last = i_last_byte;
        if (accept) begin
            case (r_cnt)
                2'd0: begin
                    n_pend0 = i_data_byte;
                    if (i_last_byte) begin
                        o_push       = 1'b1;
                        o_group.bits = {i_data_byte, 16'h0000};
                        o_group.npad = 2'd2;
                    end else begin
                        n_cnt = 2'd1;
                    end
                end
                2'd1: begin
                    n_pend1 = i_data_byte;
                    if (i_last_byte) begin
                        o_push       = 1'b1;
                        o_group.bits = {r_pend0, i_data_byte, 8'h00};
                        o_group.npad = 2'd1;
                        n_cnt        = 2'd0;
                    end else begin
                        n_cnt = 2'd2;
                    end
                end
                default: begin
                    // A third byte completes the group.
                    o_push = 1'b1;
                    n_cnt  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_pend0 <= 8'h00;
            r_pend1 <= 8'h00;
        end else begin
            r_cnt   <= n_cnt;
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, r_cnt != 2'd3, "group count reached three")

endmodule

/* hw/rtl/b64e_fifo.sv */
`include "assert_macros.svh"

module b64e_fifo #(
    parameter int DEPTH = b64e_pkg::FifoDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_group    i_group,
    output logic                o_full,
    output logic                o_valid,
    output b64e_pkg::t_group    o_group,
    input  logic                i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PtrW-1:0]  r_wptr, n_wptr;
    logic [PtrW-1:0]  r_rptr, n_rptr;
    logic [CntW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_group = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, o_full, !i_push, "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, !o_valid, !i_pop, "pop from an empty queue")

endmodule

/* hw/rtl/b64e_back.sv */
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  b64e_pkg::t_group    i_group,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);

    logic [1:0] r_idx,   n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_char,  n_char;
    logic       r_last,  n_last;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;

    // The output register takes a new character whenever a group is waiting and the
    // register is empty or its current transaction completes in this cycle.
    assign load = i_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_group.bits[23:18];
            2'd1:    sextet = i_group.bits[17:12];
            2'd2:    sextet = i_group.bits[11:6];
            default: sextet = i_group.bits[5:0];
        endcase
        is_pad = ((i_group.npad == 2'd2) && (r_idx >= 2'd2))
              || ((i_group.npad == 2'd1) && (r_idx == 2'd3));
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (load) begin
            n_idx   = r_idx + 2'd1;
            n_valid = 1'b1;
            n_char  = is_pad ? b64e_pkg::PadChar : b64e_pkg::sextet_to_char(sextet);
            n_last  = i_group.last && (r_idx == 2'd3);
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule
